>>> hdl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared sizes, command and status codes and state type of the
// move-to-front list.
// ----------------------------------------------------------------------------
package mtf_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int ID_SPACE    = 256;

   // fixed field widths
   localparam int CMD_W    = 2;
   localparam int ID_W     = 8;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;

   // internal widths
   localparam int IDX_W   = $clog2(ID_SPACE);
   localparam int PLACE_W = $clog2(MAX_ENTRIES);
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NOTIFY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SHIFT
   } state_type;

endpackage

>>> hdl/mtf_ram.sv
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/move_to_front_list.sv
// ----------------------------------------------------------------------------
// move_to_front_list
// Self-organizing move-to-front list of user ids kept in two RAMs.
// ----------------------------------------------------------------------------
// Usage: drive req_cmd and req_user_id with start high; the transaction is
// taken at a clock edge where start is high and busy is low. add appends an
// absent id at the tail unless the list is full, notify moves a present id
// to the front, lookup only reports. Every transaction yields one result on
// rsp_position, rsp_present and rsp_status, marked by rsp_valid for exactly
// one cycle and registered from the lookup state that the accepting edge
// enters. The receiver cannot stall, so results are never held.
// Shifting: add, lookup and notify of the head id pass through the lookup
// state only. A notify of an id at zero-based place p > 0 then runs the
// shift state, as the list order RAM is walked one entry per cycle from
// place p back to the head (one read and one write per cycle), then the id
// is written at the front; busy stays high until the walk is done.
// Reset: synchronous and active high; the list comes up empty, the id valid
// flags are cleared at once, no clearing pass runs.
// ----------------------------------------------------------------------------
module move_to_front_list
   import mtf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [ID_W-1:0]     req_user_id,
   output logic                rsp_valid,
   output logic [POS_W-1:0]    rsp_position,
   output logic                rsp_present,
   output logic [STATUS_W-1:0] rsp_status
);

   state_type state_ff, state_in;

   logic [ID_SPACE-1:0] valid_ff, valid_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [CMD_W-1:0]    cmd_ff;
   logic [IDX_W-1:0]    id_ff;

   logic                rd_act_ff, rd_act_in;
   logic [PLACE_W-1:0]  rd_idx_ff, rd_idx_in;
   logic                wr_pend_ff, wr_pend_in;
   logic [PLACE_W-1:0]  wr_idx_ff, wr_idx_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]    rsp_position_ff, rsp_position_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // order RAM: ids in list order
   logic               ord_wr_en;
   logic [PLACE_W-1:0] ord_wr_addr;
   logic [IDX_W-1:0]   ord_wr_data;
   logic               ord_rd_en;
   logic [IDX_W-1:0]   ord_rd_data;

   // position RAM: place of each id
   logic               pos_wr_en;
   logic [IDX_W-1:0]   pos_wr_addr;
   logic [PLACE_W-1:0] pos_wr_data;
   logic               pos_rd_en;
   logic [PLACE_W-1:0] pos_rd_data;

   logic accept;
   logic present;
   logic full;

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);
   assign present = valid_ff[id_ff];
   assign full    = (count_ff == COUNT_W'(MAX_ENTRIES));

   assign pos_rd_en = accept;
   assign ord_rd_en = rd_act_ff;

   mtf_ram #(
      .WIDTH(IDX_W),
      .DEPTH(MAX_ENTRIES)
   ) u_order_ram (
      .clock  (clock),
      .wr_en  (ord_wr_en),
      .wr_addr(ord_wr_addr),
      .wr_data(ord_wr_data),
      .rd_en  (ord_rd_en),
      .rd_addr(rd_idx_ff),
      .rd_data(ord_rd_data)
   );

   mtf_ram #(
      .WIDTH(PLACE_W),
      .DEPTH(ID_SPACE)
   ) u_position_ram (
      .clock  (clock),
      .wr_en  (pos_wr_en),
      .wr_addr(pos_wr_addr),
      .wr_data(pos_wr_data),
      .rd_en  (pos_rd_en),
      .rd_addr(req_user_id[IDX_W-1:0]),
      .rd_data(pos_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         rd_act_ff    <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rd_act_ff    <= rd_act_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_user_id[IDX_W-1:0];
      end
      rd_idx_ff       <= rd_idx_in;
      wr_idx_ff       <= wr_idx_in;
      rsp_position_ff <= rsp_position_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_status_ff   <= rsp_status_in;
   end

   always_comb begin
      state_in        = state_ff;
      valid_in        = valid_ff;
      count_in        = count_ff;
      rd_act_in       = 1'b0;
      rd_idx_in       = rd_idx_ff;
      wr_pend_in      = 1'b0;
      wr_idx_in       = wr_idx_ff;
      rsp_valid_in    = 1'b0;
      rsp_position_in = rsp_position_ff;
      rsp_present_in  = rsp_present_ff;
      rsp_status_in   = rsp_status_ff;
      ord_wr_en       = 1'b0;
      ord_wr_addr     = '0;
      ord_wr_data     = id_ff;
      pos_wr_en       = 1'b0;
      pos_wr_addr     = id_ff;
      pos_wr_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            state_in        = ST_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_present_in  = present;
            rsp_position_in = present ? POS_W'(pos_rd_data) + POS_W'(1) : '0;
            rsp_status_in   = STATUS_OK;
            if (cmd_ff == CMD_ADD) begin
               if (!present) begin
                  if (full) begin
                     rsp_status_in = STATUS_FULL;
                  end else begin
                     // append at the tail
                     ord_wr_en       = 1'b1;
                     ord_wr_addr     = count_ff[PLACE_W-1:0];
                     pos_wr_en       = 1'b1;
                     pos_wr_data     = count_ff[PLACE_W-1:0];
                     valid_in[id_ff] = 1'b1;
                     count_in        = count_ff + COUNT_W'(1);
                  end
               end
            end else if (!present) begin
               rsp_status_in = STATUS_UNKNOWN;
            end else if (cmd_ff == CMD_NOTIFY && pos_rd_data != '0) begin
               state_in  = ST_SHIFT;
               rd_act_in = 1'b1;
               rd_idx_in = pos_rd_data - PLACE_W'(1);
            end
         end

         ST_SHIFT: begin
            // read entry i-1 while entry i, read last cycle, lands at place i+1
            if (rd_act_ff) begin
               wr_pend_in = 1'b1;
               wr_idx_in  = rd_idx_ff + PLACE_W'(1);
               if (rd_idx_ff != '0) begin
                  rd_act_in = 1'b1;
                  rd_idx_in = rd_idx_ff - PLACE_W'(1);
               end
            end
            if (wr_pend_ff) begin
               ord_wr_en   = 1'b1;
               ord_wr_addr = wr_idx_ff;
               ord_wr_data = ord_rd_data;
               pos_wr_en   = 1'b1;
               pos_wr_addr = ord_rd_data;
               pos_wr_data = wr_idx_ff;
            end
            if (!rd_act_ff && !wr_pend_ff) begin
               // shifting done, put the id at the head
               ord_wr_en   = 1'b1;
               ord_wr_addr = '0;
               ord_wr_data = id_ff;
               pos_wr_en   = 1'b1;
               pos_wr_addr = id_ff;
               pos_wr_data = '0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_present  = rsp_present_ff;
   assign rsp_status   = rsp_status_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(MAX_ENTRIES))
      else $error("entry count beyond list capacity");

   a_accept_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOOKUP)
      else $error("accepted transaction did not reach lookup");

   a_rsp_after_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_LOOKUP))
      else $error("result strobe without a lookup");

   a_shift_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT && rd_act_ff && wr_pend_ff) |-> wr_idx_ff != rd_idx_ff)
      else $error("order ram read and write hit the same entry");

   a_shift_only_notify: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (cmd_ff == CMD_NOTIFY && present))
      else $error("shift running for a transaction other than notify");
`endif

endmodule

>>> tb/sv/move_to_front_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// move_to_front_list_tb
// Self-checking bench for the move-to-front list of user ids.
// A short directed run, then random add, notify and lookup traffic that fills
// the list and keeps reordering it. A shadow list inside the bench predicts
// position, present and status of each transaction.
// ----------------------------------------------------------------------------
module move_to_front_list_tb
   import mtf_pkg::*;
();

   // unused command code, handled as lookup
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  user_id;
   } list_command_type;

   typedef struct {
      logic [POS_W-1:0]    position;
      logic                present;
      logic [STATUS_W-1:0] status;
   } list_verdict_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                start       = 1'b0;
   logic [CMD_W-1:0]    req_cmd     = CMD_ADD;
   logic [ID_W-1:0]     req_user_id = '0;
   logic                busy;
   logic                rsp_valid;
   logic [POS_W-1:0]    rsp_position;
   logic                rsp_present;
   logic [STATUS_W-1:0] rsp_status;

   // shadow of the list kept in transaction order
   logic [ID_W-1:0]    order_list [MAX_ENTRIES];
   logic [PLACE_W-1:0] where_is   [ID_SPACE];
   bit                 in_list    [ID_SPACE];
   int                 list_len = 0;

   list_command_type cmd_backlog[$];
   list_verdict_type pending_verdicts[$];

   // ids the stimulus has tried to add so far
   logic [ID_W-1:0] known_ids[$];
   bit              id_offered [ID_SPACE];

   int idle_pct       = 0;
   int queued_count   = 0;
   int accepted_count = 0;
   int checked_count  = 0;
   int error_count    = 0;
   int ok_count       = 0;
   int unknown_count  = 0;
   int full_count     = 0;
   int move_count     = 0;
   int deepest_move   = 0;

   move_to_front_list dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_user_id  (req_user_id),
      .rsp_valid    (rsp_valid),
      .rsp_position (rsp_position),
      .rsp_present  (rsp_present),
      .rsp_status   (rsp_status)
   );

   always #10 clock = ~clock;

   // apply one transaction to the shadow list and queue the verdict it yields
   function automatic void apply_list_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      list_verdict_type v;
      int               place;
      bit               hit;
      hit        = in_list[id];
      place      = hit ? int'(where_is[id]) : 0;
      v.position = hit ? POS_W'(place + 1) : '0;
      v.present  = hit;
      v.status   = STATUS_OK;
      if (cmd == CMD_ADD) begin
         if (!hit) begin
            if (list_len < MAX_ENTRIES) begin
               order_list[list_len] = id;
               where_is[id]         = PLACE_W'(list_len);
               in_list[id]          = 1'b1;
               list_len++;
            end else begin
               v.status = STATUS_FULL;
            end
         end
      end else if (!hit) begin
         v.status = STATUS_UNKNOWN;
      end else if (cmd == CMD_NOTIFY) begin
         // everything ahead of the id slides back one place
         for (int i = place; i > 0; i--) begin
            order_list[i]           = order_list[i-1];
            where_is[order_list[i]] = PLACE_W'(i);
         end
         order_list[0] = id;
         where_is[id]  = '0;
         if (place > 0) move_count++;
         if (place > deepest_move) deepest_move = place;
      end
      case (v.status)
         STATUS_OK:      ok_count++;
         STATUS_UNKNOWN: unknown_count++;
         default:        full_count++;
      endcase
      pending_verdicts = {pending_verdicts, v};
   endfunction

   task automatic queue_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
      list_command_type c;
      c.cmd     = cmd;
      c.user_id = id;
      cmd_backlog = {cmd_backlog, c};
      queued_count++;
      if (cmd == CMD_ADD && !id_offered[id]) begin
         id_offered[id] = 1'b1;
         known_ids = {known_ids, id};
      end
   endtask

   // mostly ids already offered, so notify and lookup reach deep places
   task automatic queue_random_commands(int count, int add_pct);
      int              r;
      logic [CMD_W-1:0] cmd;
      logic [ID_W-1:0]  id;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < add_pct)
            cmd = CMD_ADD;
         else if (r < add_pct + (100 - add_pct) * 6 / 10)
            cmd = CMD_NOTIFY;
         else if ($urandom_range(9) == 0)
            cmd = CMD_SPARE;
         else
            cmd = CMD_LOOKUP;
         if (known_ids.size() == 0 ||
             $urandom_range(99) < ((cmd == CMD_ADD) ? 75 : 20))
            id = ID_W'($urandom_range(ID_SPACE - 1));
         else
            id = known_ids[$urandom_range(known_ids.size() - 1)];
         queue_command(cmd, id);
      end
   endtask

   task automatic wait_for_drain();
      while (cmd_backlog.size() != 0 || accepted_count != queued_count ||
             pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // driver: a transaction is taken at an edge with start high and busy low
   always @(posedge clock) begin : drive
      list_command_type c;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_list_command(req_cmd, req_user_id);
            accepted_count++;
         end
         if (!start || !busy) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
               c = cmd_backlog.pop_front();
               start       <= 1'b1;
               req_cmd     <= c.cmd;
               req_user_id <= c.user_id;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: each strobed result is compared with the oldest verdict
   always @(posedge clock) begin : watch
      list_verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $error("result with no transaction pending: position %0d present %0d status %0d",
                   rsp_position, rsp_present, rsp_status);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            checked_count++;
            if (rsp_position !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_position);
               error_count++;
            end
            if (rsp_present !== want.present) begin
               $error("present: expected %0d, actual %0d", want.present, rsp_present);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, head and tail, duplicates, code 3, absent ids
      @(negedge clock);
      idle_pct = 0;
      queue_command(CMD_LOOKUP, 8'h00);
      queue_command(CMD_NOTIFY, 8'h00);
      queue_command(CMD_SPARE,  8'h00);
      queue_command(CMD_ADD,    8'h00);
      queue_command(CMD_ADD,    8'hFF);
      queue_command(CMD_ADD,    8'h00);
      queue_command(CMD_ADD,    8'hAA);
      queue_command(CMD_ADD,    8'h55);
      queue_command(CMD_LOOKUP, 8'h55);
      queue_command(CMD_NOTIFY, 8'h55);
      queue_command(CMD_LOOKUP, 8'h55);
      queue_command(CMD_LOOKUP, 8'h00);
      queue_command(CMD_NOTIFY, 8'h55);
      queue_command(CMD_NOTIFY, 8'hFF);
      queue_command(CMD_SPARE,  8'hFF);
      queue_command(CMD_NOTIFY, 8'hAA);
      queue_command(CMD_LOOKUP, 8'h12);
      queue_command(CMD_NOTIFY, 8'h12);
      queue_command(CMD_ADD,    8'h12);
      queue_command(CMD_NOTIFY, 8'h12);
      queue_command(CMD_SPARE,  8'h7E);
      wait_for_drain();

      // add heavy first so the list fills and add to a full list shows up
      @(negedge clock);
      idle_pct = 0;
      queue_random_commands(250, 60);
      wait_for_drain();

      @(negedge clock);
      idle_pct = 79;
      queue_random_commands(250, 20);
      wait_for_drain();

      @(negedge clock);
      idle_pct = 0;
      queue_random_commands(250, 20);
      wait_for_drain();

      @(negedge clock);
      idle_pct = 6;
      queue_random_commands(250, 25);
      wait_for_drain();

      // wait out a notify from the tail before the final check
      repeat (100) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $error("%0d results never arrived", pending_verdicts.size());
         error_count++;
      end
      $display("checked %0d transactions: %0d ok, %0d unknown id, %0d list full",
               checked_count, ok_count, unknown_count, full_count);
      $display("%0d moves to front, deepest from place %0d, final list length %0d",
               move_count, deepest_move, list_len);
      if (error_count == 0)
         $display("move_to_front_list: match");
      else
         $display("move_to_front_list: mismatch");
      $finish;
   end

   initial begin
      #10ms;
      $display("timeout waiting for results");
      $display("move_to_front_list: mismatch");
      $finish;
   end

endmodule
